// ===== rtl/text_console_writer_core_macros.svh =====
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shared property shorthands for the console checker.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_CORE_MACROS_SVH
`define TEXT_CONSOLE_WRITER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define TCW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Field widths, command and byte codes, and shared types of the text console.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    // Item field widths
    localparam int OPCODE_W     = 2;
    localparam int CHAR_W       = 8;
    localparam int ADDR_FIELD_W = 13;
    localparam int CELL_W       = 16;
    localparam int ATTR_W       = 8;
    localparam int CFG_INDEX_W  = 2;
    localparam int MEM_ADDR_W   = 16;

    // Command codes
    localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TEXT_ATTRIBUTE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLANK_CELL     = 2'd1;

    // Register reset values
    localparam logic [ATTR_W-1:0] RESET_ATTRIBUTE = 8'h07;
    localparam logic [CELL_W-1:0] RESET_BLANK     = 16'h0720;

    // Byte codes
    localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
    localparam logic [CHAR_W-1:0] CH_ENQ = 8'h05;
    localparam logic [CHAR_W-1:0] CH_BEL = 8'h07;
    localparam logic [CHAR_W-1:0] CH_BS  = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF  = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT  = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF  = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR  = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_ESC = 8'h1B;
    localparam logic [CHAR_W-1:0] CH_DEL = 8'h7F;

    // Operation of the shared address unit
    typedef enum logic {
        ADDR_ADD,
        ADDR_SUB
    } addr_op_t;

    // Byte handling classes
    typedef enum logic [2:0] {
        BC_IGNORE,
        BC_BS,
        BC_LF,
        BC_FF,
        BC_CR,
        BC_DEL,
        BC_GLYPH
    } byte_class_t;

    // Video memory write request
    typedef struct packed {
        logic                  en;
        logic [MEM_ADDR_W-1:0] addr;
        logic [CELL_W-1:0]     data;
    } mem_wr_t;

    function automatic byte_class_t classify_byte(input logic [CHAR_W-1:0] ch);
        byte_class_t bc;
        case (ch) inside
            CH_NUL, CH_ENQ, CH_BEL, CH_TAB, CH_VT, CH_ESC: bc = BC_IGNORE;
            CH_BS:   bc = BC_BS;
            CH_LF:   bc = BC_LF;
            CH_FF:   bc = BC_FF;
            CH_CR:   bc = BC_CR;
            CH_DEL:  bc = BC_DEL;
            default: bc = BC_GLYPH;
        endcase
        return bc;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/text_console_writer_core.sv =====
// Flow: a printable byte is stored in S_BYTE and posted from S_FIN; a wrap, LF or FF
// also passes S_LA, CR goes via S_CR, and BS or DEL via S_BLANK. A scroll blanks the
// row below the screen, first copying the screen to cell 0 on relocation. Clear sweeps
// all cells; a read goes via S_RD. One item in flight at a time: S_FIN waits for a free
// result slot, and the next item is taken in S_IDLE. Reset: async active low; then a
// blanking sweep over every cell runs with s_tready low (config writes are still taken).
// ----------------------------------------------------------------------------
// text_console_writer_core
// Character-cell text console: byte writes, screen clear and cell reads on a
// video memory, with a sequencer driving one shared address adder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_core #(
    parameter int MEMORY_CELLS = 8192,
    parameter int COLUMNS      = 80,
    parameter int ROWS         = 25
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,   // [7:0] char_byte, [20:8] cell_address
    input  logic [tcw_pkg::OPCODE_W-1:0]        s_tuser,   // [1:0] opcode
    input  logic                                s_tlast,   // end_of_buffer
    // Result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [47:0]                         m_tdata,   // [12:0] shown_cursor,
                                                           // [25:13] screen_start,
                                                           // [41:26] read_cell
    // Configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [tcw_pkg::CELL_W-1:0]          cfg_data
);
    import tcw_pkg::*;

    localparam int AW           = $clog2(MEMORY_CELLS);
    localparam int CLW          = $clog2(COLUMNS + 1);
    localparam int RW           = $clog2(ROWS);
    localparam int SCREEN_CELLS = ROWS * COLUMNS;
    localparam int SCREEN_MOD   = SCREEN_CELLS % MEMORY_CELLS;
    localparam int SCROLL_LIMIT = MEMORY_CELLS - SCREEN_CELLS - COLUMNS;
    localparam int RELOC_FROM_I = (SCROLL_LIMIT > 0) ? SCROLL_LIMIT : 0;
    localparam int CNT_MAX      = (MEMORY_CELLS > SCREEN_CELLS) ? MEMORY_CELLS
                                                                : SCREEN_CELLS;
    localparam int CNT_W        = $clog2(CNT_MAX);

    localparam logic [AW-1:0]    RELOC_FROM = AW'(RELOC_FROM_I);
    localparam logic [AW-1:0]    ONE_CELL   = AW'(1);
    localparam logic [AW-1:0]    ROW_STEP   = AW'(COLUMNS);
    localparam logic [AW-1:0]    SCREEN_OFS = AW'(SCREEN_MOD);
    localparam logic [CLW-1:0]   COL_LIMIT  = CLW'(COLUMNS);
    localparam logic [RW-1:0]    LAST_ROW   = RW'(ROWS - 1);
    localparam logic [CNT_W-1:0] SWEEP_LAST = CNT_W'(MEMORY_CELLS - 1);
    localparam logic [CNT_W-1:0] COPY_LAST  = CNT_W'(SCREEN_CELLS - 1);
    localparam logic [CNT_W-1:0] ROW_LAST   = CNT_W'(COLUMNS - 1);

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_BYTE,
        S_LA,
        S_CP_RD,
        S_CP_WR,
        S_REL,
        S_BR_BASE,
        S_BR_WR,
        S_ST_ADV,
        S_CUR_ADV,
        S_PUT,
        S_CR,
        S_BLANK,
        S_RD,
        S_FIN
    } state_t;

    // What follows a line advance
    typedef enum logic [1:0] {
        FOL_NONE,
        FOL_CR,
        FOL_PUT
    } follow_t;

    state_t                  state_reg,   state_next;
    follow_t                 follow_reg,  follow_next;
    logic                    clr_rst_reg, clr_rst_next;
    logic [OPCODE_W-1:0]     opcode_reg,  opcode_next;
    logic [CHAR_W-1:0]       char_reg,    char_next;
    logic                    eob_reg,     eob_next;
    logic [ADDR_FIELD_W-1:0] caddr_reg,   caddr_next;
    logic [ATTR_W-1:0]       attr_reg,    attr_next;
    logic [CELL_W-1:0]       blank_reg,   blank_next;
    logic [AW-1:0]           start_reg,   start_next;
    logic [AW-1:0]           cursor_reg,  cursor_next;
    logic [CLW-1:0]          column_reg,  column_next;
    logic [RW-1:0]           row_reg,     row_next;
    logic [AW-1:0]           pub_reg,     pub_next;
    logic [AW-1:0]           src_reg,     src_next;
    logic [AW-1:0]           dst_reg,     dst_next;
    logic [CNT_W-1:0]        cnt_reg,     cnt_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [ADDR_FIELD_W-1:0] shown_reg,   shown_next;
    logic [ADDR_FIELD_W-1:0] sstart_reg,  sstart_next;
    logic [CELL_W-1:0]       rcell_reg,   rcell_next;

    addr_op_t                unit_op;
    logic [AW-1:0]           unit_a;
    logic [AW-1:0]           unit_b;
    logic [AW-1:0]           unit_y;

    mem_wr_t                 mem_wr;
    logic                    mem_rd_en;
    logic [AW-1:0]           mem_rd_addr;
    logic [CELL_W-1:0]       mem_rd_data;

    state_t                  follow_state;
    byte_class_t             byte_class;
    logic [16:0]             caddr_ext;
    logic [16:0]             caddr_mod;
    logic [AW-1:0]           pub_final;

    // Shared address adder
    tcw_addr_unit #(
        .MEMORY_CELLS (MEMORY_CELLS)
    ) u_addr_unit (
        .op (unit_op),
        .a  (unit_a),
        .b  (unit_b),
        .y  (unit_y)
    );

    // Video cell memory
    tcw_video_mem #(
        .MEMORY_CELLS (MEMORY_CELLS)
    ) u_video_mem (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Read address folded into the memory range
    assign caddr_ext  = 17'(caddr_reg);
    assign caddr_mod  = (caddr_ext >= 17'(MEMORY_CELLS)) ? caddr_ext - 17'(MEMORY_CELLS)
                                                         : caddr_ext;
    assign byte_class = classify_byte(char_reg);
    assign pub_final  = ((opcode_reg == OP_WRITE) && eob_reg) ? cursor_reg : pub_reg;

    // Resume point after a line advance
    always_comb
    begin
        case (follow_reg)
            FOL_PUT: follow_state = S_PUT;
            FOL_CR:  follow_state = S_CR;
            default: follow_state = S_FIN;
        endcase
    end

    // Sequencer next state
    always_comb
    begin
        state_next    = state_reg;
        follow_next   = follow_reg;
        clr_rst_next  = clr_rst_reg;
        opcode_next   = opcode_reg;
        char_next     = char_reg;
        eob_next      = eob_reg;
        caddr_next    = caddr_reg;
        attr_next     = attr_reg;
        blank_next    = blank_reg;
        start_next    = start_reg;
        cursor_next   = cursor_reg;
        column_next   = column_reg;
        row_next      = row_reg;
        pub_next      = pub_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        shown_next    = shown_reg;
        sstart_next   = sstart_reg;
        rcell_next    = rcell_reg;

        unit_op       = ADDR_ADD;
        unit_a        = cursor_reg;
        unit_b        = ONE_CELL;
        mem_wr        = '0;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = src_reg;

        // Configuration writes
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TEXT_ATTRIBUTE: attr_next  = cfg_data[ATTR_W-1:0];
                REG_BLANK_CELL:     blank_next = cfg_data;
                default: ;
            endcase
        end

        // Result slot drains
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            // Blank sweep over the whole memory
            S_CLR:
            begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = MEM_ADDR_W'(dst_reg);
                mem_wr.data = clr_rst_reg ? RESET_BLANK : blank_reg;
                unit_a      = dst_reg;
                dst_next    = unit_y;
                cnt_next    = cnt_reg + CNT_W'(1);
                if (cnt_reg == SWEEP_LAST)
                begin
                    clr_rst_next = 1'b0;
                    state_next   = clr_rst_reg ? S_IDLE : S_FIN;
                end
            end

            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    opcode_next = s_tuser;
                    char_next   = s_tdata[CHAR_W-1:0];
                    caddr_next  = s_tdata[CHAR_W +: ADDR_FIELD_W];
                    eob_next    = s_tlast;
                    unique case (s_tuser)
                        OP_WRITE: state_next = S_BYTE;
                        OP_CLEAR:
                        begin
                            start_next  = '0;
                            cursor_next = '0;
                            column_next = '0;
                            row_next    = '0;
                            pub_next    = '0;
                            dst_next    = '0;
                            cnt_next    = '0;
                            state_next  = S_CLR;
                        end
                        OP_READ:  state_next = S_RD;
                        default:  state_next = S_FIN;
                    endcase
                end
            end

            // Byte dispatch; a glyph is stored here directly unless the line must wrap first
            S_BYTE:
            begin
                unique case (byte_class)
                    BC_IGNORE: state_next = S_FIN;
                    BC_BS:
                    begin
                        if (column_reg != '0)
                        begin
                            column_next = column_reg - CLW'(1);
                            unit_op     = ADDR_SUB;
                            cursor_next = unit_y;
                            state_next  = S_BLANK;
                        end
                        else
                        begin
                            state_next = S_FIN;
                        end
                    end
                    BC_LF:
                    begin
                        follow_next = FOL_CR;
                        state_next  = S_LA;
                    end
                    BC_FF:
                    begin
                        follow_next = FOL_NONE;
                        state_next  = S_LA;
                    end
                    BC_CR:  state_next = S_CR;
                    BC_DEL: state_next = S_BLANK;
                    default:
                    begin
                        if (column_reg >= COL_LIMIT)
                        begin
                            // Lazy wrap: back to line start, then advance
                            column_next = '0;
                            unit_op     = ADDR_SUB;
                            unit_b      = ROW_STEP;
                            cursor_next = unit_y;
                            follow_next = FOL_PUT;
                            state_next  = S_LA;
                        end
                        else
                        begin
                            mem_wr.en   = 1'b1;
                            mem_wr.addr = MEM_ADDR_W'(cursor_reg);
                            mem_wr.data = {attr_reg, char_reg};
                            cursor_next = unit_y;
                            column_next = column_reg + CLW'(1);
                            state_next  = S_FIN;
                        end
                    end
                endcase
            end

            // Line advance: move down, or scroll on the bottom row
            S_LA:
            begin
                if (row_reg != LAST_ROW)
                begin
                    row_next    = row_reg + RW'(1);
                    unit_b      = ROW_STEP;
                    cursor_next = unit_y;
                    pub_next    = unit_y;
                    state_next  = follow_state;
                end
                else if (start_reg >= RELOC_FROM)
                begin
                    src_next   = start_reg;
                    dst_next   = '0;
                    cnt_next   = '0;
                    state_next = S_CP_RD;
                end
                else
                begin
                    state_next = S_BR_BASE;
                end
            end

            // Screen relocation to cell 0, one read and one write per cell
            S_CP_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = src_reg;
                unit_a      = src_reg;
                src_next    = unit_y;
                state_next  = S_CP_WR;
            end

            S_CP_WR:
            begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = MEM_ADDR_W'(dst_reg);
                mem_wr.data = mem_rd_data;
                unit_a      = dst_reg;
                dst_next    = unit_y;
                cnt_next    = cnt_reg + CNT_W'(1);
                state_next  = (cnt_reg == COPY_LAST) ? S_REL : S_CP_RD;
            end

            S_REL:
            begin
                unit_op     = ADDR_SUB;
                unit_b      = start_reg;
                cursor_next = unit_y;
                start_next  = '0;
                state_next  = S_BR_BASE;
            end

            // Blank the row just below the screen
            S_BR_BASE:
            begin
                unit_a     = start_reg;
                unit_b     = SCREEN_OFS;
                dst_next   = unit_y;
                cnt_next   = '0;
                state_next = S_BR_WR;
            end

            S_BR_WR:
            begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = MEM_ADDR_W'(dst_reg);
                mem_wr.data = blank_reg;
                unit_a      = dst_reg;
                dst_next    = unit_y;
                cnt_next    = cnt_reg + CNT_W'(1);
                if (cnt_reg == ROW_LAST)
                begin
                    state_next = S_ST_ADV;
                end
            end

            S_ST_ADV:
            begin
                unit_a     = start_reg;
                unit_b     = ROW_STEP;
                start_next = unit_y;
                state_next = S_CUR_ADV;
            end

            S_CUR_ADV:
            begin
                unit_b      = ROW_STEP;
                cursor_next = unit_y;
                state_next  = follow_state;
            end

            S_PUT:
            begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = MEM_ADDR_W'(cursor_reg);
                mem_wr.data = {attr_reg, char_reg};
                cursor_next = unit_y;
                column_next = column_reg + CLW'(1);
                state_next  = S_FIN;
            end

            S_CR:
            begin
                unit_op     = ADDR_SUB;
                unit_b      = AW'(column_reg);
                cursor_next = unit_y;
                column_next = '0;
                state_next  = S_FIN;
            end

            S_BLANK:
            begin
                mem_wr.en   = 1'b1;
                mem_wr.addr = MEM_ADDR_W'(cursor_reg);
                mem_wr.data = blank_reg;
                state_next  = S_FIN;
            end

            S_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = caddr_mod[AW-1:0];
                state_next  = S_FIN;
            end

            // Publish the cursor on end of buffer and post the result
            S_FIN:
            begin
                pub_next = pub_final;
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    shown_next    = ADDR_FIELD_W'(pub_final);
                    sstart_next   = ADDR_FIELD_W'(start_reg);
                    rcell_next    = (opcode_reg == OP_READ) ? mem_rd_data : '0;
                    state_next    = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            follow_reg   <= FOL_NONE;
            clr_rst_reg  <= 1'b1;
            opcode_reg   <= OP_WRITE;
            char_reg     <= '0;
            eob_reg      <= 1'b0;
            caddr_reg    <= '0;
            attr_reg     <= RESET_ATTRIBUTE;
            blank_reg    <= RESET_BLANK;
            start_reg    <= '0;
            cursor_reg   <= '0;
            column_reg   <= '0;
            row_reg      <= '0;
            pub_reg      <= '0;
            src_reg      <= '0;
            dst_reg      <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            shown_reg    <= '0;
            sstart_reg   <= '0;
            rcell_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            follow_reg   <= follow_next;
            clr_rst_reg  <= clr_rst_next;
            opcode_reg   <= opcode_next;
            char_reg     <= char_next;
            eob_reg      <= eob_next;
            caddr_reg    <= caddr_next;
            attr_reg     <= attr_next;
            blank_reg    <= blank_next;
            start_reg    <= start_next;
            cursor_reg   <= cursor_next;
            column_reg   <= column_next;
            row_reg      <= row_next;
            pub_reg      <= pub_next;
            src_reg      <= src_next;
            dst_reg      <= dst_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            shown_reg    <= shown_next;
            sstart_reg   <= sstart_next;
            rcell_reg    <= rcell_next;
        end
    end

    // Ports
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {6'b0, rcell_reg, sstart_reg, shown_reg};

endmodule

`default_nettype wire

// ===== rtl/tcw_addr_unit.sv =====
// ----------------------------------------------------------------------------
// tcw_addr_unit
// Shared cell address adder: add or subtract modulo the video memory size.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_addr_unit #(
    parameter int MEMORY_CELLS = 8192
) (
    input  tcw_pkg::addr_op_t                 op,
    input  logic [$clog2(MEMORY_CELLS)-1:0]   a,
    input  logic [$clog2(MEMORY_CELLS)-1:0]   b,
    output logic [$clog2(MEMORY_CELLS)-1:0]   y
);
    import tcw_pkg::*;

    localparam int AW = $clog2(MEMORY_CELLS);
    localparam logic [AW:0] MOD = (AW+1)'(MEMORY_CELLS);

    logic [AW:0] sum_raw;
    logic [AW:0] sum_wrap;
    logic [AW:0] diff_wrap;

    // Both operands stay below the modulus, so one correction step is enough
    assign sum_raw   = {1'b0, a} + {1'b0, b};
    assign sum_wrap  = (sum_raw >= MOD) ? sum_raw - MOD : sum_raw;
    assign diff_wrap = (a >= b) ? {1'b0, a} - {1'b0, b}
                                : {1'b0, a} + MOD - {1'b0, b};

    always_comb
    begin
        case (op)
            ADDR_ADD: y = sum_wrap[AW-1:0];
            default:  y = diff_wrap[AW-1:0];
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/tcw_video_mem.sv =====
// ----------------------------------------------------------------------------
// tcw_video_mem
// Video cell memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcw_video_mem #(
    parameter int MEMORY_CELLS = 8192
) (
    input  logic                              clk,
    input  tcw_pkg::mem_wr_t                  wr,
    input  logic                              rd_en,
    input  logic [$clog2(MEMORY_CELLS)-1:0]   rd_addr,
    output logic [tcw_pkg::CELL_W-1:0]        rd_data
);
    import tcw_pkg::*;

    localparam int AW = $clog2(MEMORY_CELLS);

    logic [CELL_W-1:0] cells [MEMORY_CELLS];
    logic [CELL_W-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            cells[wr.addr[AW-1:0]] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= cells[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/tcw_checker.sv =====
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console: output hold, busy after accept,
// and results posted only while the input side is closed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "text_console_writer_core_macros.svh"

module tcw_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata
);

    // A stalled result item holds
    `TCW_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result item changed while stalled")

    // One item at a time: busy right after an accept
    `TCW_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready, "input accepted while an item is in work")

    // A new result appears only from the finishing step
    `TCW_ASSERT_SAME(a_result_from_work, clk, rst_n, $rose(m_tvalid), $past(!s_tready), "result posted while input side was open")

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
